@@ src/rms_voice_activity_detector_macros.svh @@
// ----------------------------------------------------------------------------
// RMS voice activity detector assertion macros
// Assertion wrappers for the detector; they expand to nothing when SYNTH is set.
// They sample on the rising edge of clock and are held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef RMS_VOICE_ACTIVITY_DETECTOR_MACROS_SVH
`define RMS_VOICE_ACTIVITY_DETECTOR_MACROS_SVH
`ifndef SYNTH
`define RVAD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define RVAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RVAD_ASSERT_IMPL(label, ante, cons, msg)
`define RVAD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ src/rvad_pkg.sv @@
// ----------------------------------------------------------------------------
// RMS voice activity detector package
// Widths, codes and the command and status types shared by the detector.
// ----------------------------------------------------------------------------
package rvad_pkg;

   localparam int CHUNK_MAX = 512;

   localparam int MODE_W    = 2;
   localparam int SAMPLE_W  = 16;
   localparam int CFG_W     = 16;
   localparam int LEN_W     = 10;
   localparam int ROOT_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int CNT_W  = $clog2(CHUNK_MAX + 1);
   localparam int SQ_W   = 2 * SAMPLE_W - 1;
   localparam int MEAN_W = 2 * ROOT_W;
   localparam int SUM_W  = (SQ_W - 1 + CNT_W > MEAN_W) ? SQ_W - 1 + CNT_W : MEAN_W;
   localparam int REM_W  = ROOT_W + 4;
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_START  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STOP   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RMS_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LIMIT = 2'd1;

   localparam logic [CFG_W-1:0] RMS_THRESHOLD_RESET = 16'd200;
   localparam logic [CFG_W-1:0] SILENCE_LIMIT_RESET = 16'd100;
   localparam logic [CFG_W-1:0] SILENCE_SAT         = '1;

   typedef struct packed {
      logic start;
      logic stop;
      logic tick;
      logic sample;
      logic accum;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic finish;
   } rvad_cmd_type;

   typedef struct packed {
      logic listening;
      logic close;
      logic out_free;
   } rvad_status_type;

endpackage

@@ src/rvad_ctrl.sv @@
// ----------------------------------------------------------------------------
// RMS voice activity detector controller
// Decodes input beats and sequences accumulation, division and square root.
// ----------------------------------------------------------------------------
module rvad_ctrl
   import rvad_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [MODE_W-1:0]    req_mode,
   input  rvad_status_type      sts,
   output rvad_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ACCUM  = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SINIT  = 3'd3;
   localparam logic [2:0] ST_SQRT   = 3'd4;
   localparam logic [2:0] ST_RESULT = 3'd5;

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  MODE_START: cmd.start = !sts.listening;
                  MODE_STOP:  cmd.stop  = sts.listening;
                  MODE_TICK:  cmd.tick  = sts.listening;
                  MODE_SAMPLE: begin
                     if (sts.listening) begin
                        cmd.sample = 1'b1;
                        state_in   = ST_ACCUM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            step_in   = '0;
            state_in  = sts.close ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_SINIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SINIT: begin
            cmd.sqrt_init = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == SQRT_LAST) begin
               step_in  = '0;
               state_in = ST_RESULT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ src/rvad_dpath.sv @@
// ----------------------------------------------------------------------------
// RMS voice activity detector datapath
// Squares and sums samples, divides by the chunk length, takes the square
// root one bit per cycle and holds the registers and the result beat.
// ----------------------------------------------------------------------------
module rvad_dpath
   import rvad_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  rvad_cmd_type                cmd,
   output rvad_status_type             sts,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_chunk_end,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ROOT_W-1:0]           rsp_rms_value,
   output logic [LEN_W-1:0]            rsp_chunk_length,
   output logic                        rsp_is_voice,
   output logic                        rsp_forward_chunk,
   output logic                        rsp_stopped
);

   localparam logic [CNT_W-1:0] CHUNK_MAX_C = CNT_W'(CHUNK_MAX);

   logic [CFG_W-1:0]  thr_ff, limit_ff, silence_ff;
   logic              listening_ff, voice_seen_ff;
   logic [SUM_W-1:0]  sum_ff, quo_ff;
   logic [CNT_W-1:0]  cnt_ff, div_ff, len_ff, rem_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic              close_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  srem_ff;
   logic              rsp_valid_ff;
   logic [ROOT_W-1:0] rms_ff;
   logic [LEN_W-1:0]  length_ff;
   logic              voice_ff, fwd_ff, stop_ff;

   logic signed [2*SAMPLE_W-1:0] prod;
   logic [CNT_W-1:0]  cnt_next;
   logic [SUM_W-1:0]  sum_next;
   logic [CNT_W:0]    rem_sh, rem_diff;
   logic              div_ge;
   logic [REM_W-1:0]  srem_sh, trial;
   logic              sqrt_ge;
   logic              voice, stop;

   assign prod     = req_sample * req_sample;
   assign cnt_next = cnt_ff + 1'b1;
   assign sum_next = sum_ff + SUM_W'(sq_ff);

   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, div_ff};
   assign div_ge   = (rem_sh >= {1'b0, div_ff});

   assign srem_sh  = {srem_ff[REM_W-3:0], mean_ff[MEAN_W-1 -: 2]};
   assign trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign sqrt_ge  = (srem_sh >= trial);

   assign voice = (root_ff >= thr_ff);
   assign stop  = !voice && voice_seen_ff && (silence_ff >= limit_ff);

   assign csr_ready     = 1'b1;
   assign sts.listening = listening_ff;
   assign sts.close     = close_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rms_value     = rms_ff;
   assign rsp_chunk_length  = length_ff;
   assign rsp_is_voice      = voice_ff;
   assign rsp_forward_chunk = fwd_ff;
   assign rsp_stopped       = stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= RMS_THRESHOLD_RESET;
         limit_ff      <= SILENCE_LIMIT_RESET;
         listening_ff  <= 1'b0;
         voice_seen_ff <= 1'b0;
         silence_ff    <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_RMS_THRESHOLD: thr_ff   <= csr_data;
               CSR_SILENCE_LIMIT: limit_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.start) begin
            listening_ff  <= 1'b1;
            voice_seen_ff <= 1'b0;
            silence_ff    <= '0;
            sum_ff        <= '0;
            cnt_ff        <= '0;
         end
         if (cmd.stop) begin
            listening_ff <= 1'b0;
            sum_ff       <= '0;
            cnt_ff       <= '0;
         end
         if (cmd.tick && (silence_ff != SILENCE_SAT)) begin
            silence_ff <= silence_ff + 1'b1;
         end
         if (cmd.sample) begin
            cnt_ff <= cnt_next;
         end
         if (cmd.accum) begin
            if (close_ff) begin
               sum_ff <= '0;
               cnt_ff <= '0;
            end else begin
               sum_ff <= sum_next;
            end
         end
         if (cmd.finish) begin
            if (voice) begin
               voice_seen_ff <= 1'b1;
               silence_ff    <= '0;
            end
            if (stop) begin
               listening_ff <= 1'b0;
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample) begin
         sq_ff    <= prod[SQ_W-1:0];
         close_ff <= req_chunk_end || (cnt_next >= CHUNK_MAX_C);
      end
      if (cmd.accum && close_ff) begin
         quo_ff <= sum_next;
         rem_ff <= '0;
         div_ff <= cnt_ff;
         len_ff <= cnt_ff;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], div_ge};
         rem_ff <= div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      end
      if (cmd.sqrt_init) begin
         mean_ff <= quo_ff[MEAN_W-1:0];
         root_ff <= '0;
         srem_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         mean_ff <= {mean_ff[MEAN_W-3:0], 2'b00};
         srem_ff <= sqrt_ge ? (srem_sh - trial) : srem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], sqrt_ge};
      end
      if (cmd.finish) begin
         rms_ff    <= root_ff;
         length_ff <= LEN_W'(len_ff);
         voice_ff  <= voice;
         fwd_ff    <= voice || voice_seen_ff;
         stop_ff   <= stop;
      end
   end

endmodule

@@ src/rms_voice_activity_detector.sv @@
// ----------------------------------------------------------------------------
// RMS voice activity detector
// Gathers PCM samples into chunks, computes each chunk's rms and decides
// whether the chunk is voice, is passed on, or ends recording on silence.
//
//   Channel   Direction   Handshake             Beat contents
//   req       in          req_valid/req_stall   mode, sample, chunk_end
//   rsp       out         rsp_valid/rsp_stall   rms, length, voice, forward, stopped
//   csr       in          csr_valid/csr_ready   register index, write data
//
// Ticks, start and stop beats are taken straight from the idle state; a sample that
// does not close its chunk is squared, then accumulated. A sample that closes a chunk
// is also divided by the chunk length and square-rooted, by the one-bit-per-cycle
// restoring divider and the one-bit-per-cycle square root, before its result beat.
// Reset is synchronous and leaves the block idle with default registers.
// A held result stalls a finishing chunk close, and with it every input beat.
// ----------------------------------------------------------------------------
`include "rms_voice_activity_detector_macros.svh"

module rms_voice_activity_detector
   import rvad_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_chunk_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ROOT_W-1:0]           rsp_rms_value,
   output logic [LEN_W-1:0]            rsp_chunk_length,
   output logic                        rsp_is_voice,
   output logic                        rsp_forward_chunk,
   output logic                        rsp_stopped,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_data
);

   rvad_cmd_type    dp_cmd;
   rvad_status_type dp_sts;

   rvad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   rvad_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .req_sample        (req_sample),
      .req_chunk_end     (req_chunk_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rms_value     (rsp_rms_value),
      .rsp_chunk_length  (rsp_chunk_length),
      .rsp_is_voice      (rsp_is_voice),
      .rsp_forward_chunk (rsp_forward_chunk),
      .rsp_stopped       (rsp_stopped)
   );

   `RVAD_ASSERT_IMPL(a_finish_free, dp_cmd.finish, !rsp_valid || !rsp_stall, "beat overwritten")
   `RVAD_ASSERT_IMPL(a_rms_range, rsp_valid, rsp_rms_value <= 16'd32768, "rms out of range")
   `RVAD_ASSERT_IMPL(a_stop_fwd, rsp_valid && rsp_stopped, rsp_forward_chunk, "stop dropped")
   `RVAD_ASSERT_IMPL(a_stop_quiet, rsp_valid && rsp_stopped, !rsp_is_voice, "stop on voice")
   `RVAD_ASSERT_NEXT(a_finish_valid, dp_cmd.finish, rsp_valid, "no result beat")

endmodule

@@ verif/rvad_chunk_checker.sv @@
// ----------------------------------------------------------------------------
// RMS voice activity detector chunk checker
// Watches the request, result and register channels of the detector, keeps
// its own copy of the listening state, chunk energy and registers, predicts
// the result of every chunk close and compares each result beat with the
// oldest prediction, one field at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rvad_chunk_checker
   import rvad_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_chunk_end,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [ROOT_W-1:0]           rsp_rms_value,
   input  logic [LEN_W-1:0]            rsp_chunk_length,
   input  logic                        rsp_is_voice,
   input  logic                        rsp_forward_chunk,
   input  logic                        rsp_stopped,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_data,
   output int                          mismatches,
   output int                          chunks_pending
);

   typedef struct packed {
      logic [ROOT_W-1:0] rms_value;
      logic [LEN_W-1:0]  chunk_length;
      logic              is_voice;
      logic              forward_chunk;
      logic              stopped;
   } chunk_result_type;

   chunk_result_type  expected_chunks[$];
   logic [CFG_W-1:0]  threshold_q;
   logic [CFG_W-1:0]  silence_limit_q;
   logic [63:0]       energy_acc;
   int unsigned       chunk_fill;
   logic              voice_heard;
   logic              armed;
   logic [CFG_W-1:0]  silent_ticks;

   function automatic int unsigned floor_sqrt(input logic [31:0] val);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 64'd65536;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= val) lo = mid;
         else hi = mid;
      end
      return lo[31:0];
   endfunction

   task automatic update_vad_state(input logic [MODE_W-1:0] mode,
                                   input logic [SAMPLE_W-1:0] smp,
                                   input logic last);
      int               sval;
      logic [31:0]      mean;
      int unsigned      root;
      chunk_result_type res;
      unique case (mode)
         MODE_START: begin
            if (!armed) begin
               armed = 1'b1;
               voice_heard = 1'b0;
               silent_ticks = '0;
               energy_acc = '0;
               chunk_fill = 0;
            end
         end
         MODE_STOP: begin
            if (armed) begin
               armed = 1'b0;
               energy_acc = '0;
               chunk_fill = 0;
            end
         end
         MODE_TICK: begin
            if (armed && silent_ticks != SILENCE_SAT) silent_ticks = silent_ticks + 1'b1;
         end
         default: begin
            if (armed) begin
               sval = $signed(smp);
               energy_acc = energy_acc + 64'(sval * sval);
               chunk_fill++;
               if (last || chunk_fill >= CHUNK_MAX) begin
                  mean = 32'(energy_acc / 64'(chunk_fill));
                  root = floor_sqrt(mean);
                  res.rms_value = root[ROOT_W-1:0];
                  res.chunk_length = chunk_fill[LEN_W-1:0];
                  res.is_voice = (root >= threshold_q);
                  if (res.is_voice) begin
                     voice_heard = 1'b1;
                     silent_ticks = '0;
                     res.forward_chunk = 1'b1;
                     res.stopped = 1'b0;
                  end else begin
                     res.forward_chunk = voice_heard;
                     res.stopped = voice_heard && (silent_ticks >= silence_limit_q);
                  end
                  energy_acc = '0;
                  chunk_fill = 0;
                  if (res.stopped) armed = 1'b0;
                  expected_chunks.push_back(res);
               end
            end
         end
      endcase
   endtask

   task automatic check_chunk(input chunk_result_type got);
      chunk_result_type want;
      if (expected_chunks.size() == 0) begin
         $error("result beat with no chunk pending: rms_value %0d, chunk_length %0d",
                got.rms_value, got.chunk_length);
         mismatches++;
      end else begin
         want = expected_chunks.pop_front();
         if (got.rms_value !== want.rms_value) begin
            $error("rms_value: expected %0d, actual %0d", want.rms_value, got.rms_value);
            mismatches++;
         end
         if (got.chunk_length !== want.chunk_length) begin
            $error("chunk_length: expected %0d, actual %0d",
                   want.chunk_length, got.chunk_length);
            mismatches++;
         end
         if (got.is_voice !== want.is_voice) begin
            $error("is_voice: expected %0d, actual %0d", want.is_voice, got.is_voice);
            mismatches++;
         end
         if (got.forward_chunk !== want.forward_chunk) begin
            $error("forward_chunk: expected %0d, actual %0d",
                   want.forward_chunk, got.forward_chunk);
            mismatches++;
         end
         if (got.stopped !== want.stopped) begin
            $error("stopped: expected %0d, actual %0d", want.stopped, got.stopped);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold_q = RMS_THRESHOLD_RESET;
         silence_limit_q = SILENCE_LIMIT_RESET;
         energy_acc = '0;
         chunk_fill = 0;
         voice_heard = 1'b0;
         silent_ticks = '0;
         armed = 1'b0;
         mismatches = 0;
         expected_chunks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RMS_THRESHOLD) threshold_q = csr_data;
            else if (csr_index == CSR_SILENCE_LIMIT) silence_limit_q = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            check_chunk({rsp_rms_value, rsp_chunk_length, rsp_is_voice,
                         rsp_forward_chunk, rsp_stopped});
         end
         if (req_valid && !req_stall) update_vad_state(req_mode, req_sample, req_chunk_end);
      end
      chunks_pending = expected_chunks.size();
   end

endmodule

@@ verif/rms_voice_activity_detector_tb.sv @@
// ----------------------------------------------------------------------------
// RMS voice activity detector testbench
// Drives sample, tick, start and stop beats and register writes into the
// detector: a directed opening that walks the idle, start, stop, threshold
// and timeout cases, then random listening sessions under several register
// settings and a full-length chunk of maximum energy. Both channels idle at
// random; the chunk checker beside the detector predicts and compares every
// result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rms_voice_activity_detector_tb;
   import rvad_pkg::*;

   localparam int SETTLE_CYCLES = SUM_W + ROOT_W + 4 + 16;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [MODE_W-1:0]           req_mode = MODE_SAMPLE;
   logic signed [SAMPLE_W-1:0]  req_sample = '0;
   logic                        req_chunk_end = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ROOT_W-1:0]           rsp_rms_value;
   logic [LEN_W-1:0]            rsp_chunk_length;
   logic                        rsp_is_voice;
   logic                        rsp_forward_chunk;
   logic                        rsp_stopped;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_RMS_THRESHOLD;
   logic [CFG_W-1:0]            csr_data = '0;
   int                          mismatches;
   int                          chunks_pending;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int thresh_now = int'(RMS_THRESHOLD_RESET);
   int limit_now = int'(SILENCE_LIMIT_RESET);
   int beats_sent = 0;

   rms_voice_activity_detector dut (.*);

   rvad_chunk_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [SAMPLE_W-1:0] smp,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sample <= smp;
      req_chunk_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (chunks_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input int thresh, input int limit);
      write_reg(CSR_RMS_THRESHOLD, thresh[CFG_W-1:0]);
      write_reg(CSR_SILENCE_LIMIT, limit[CFG_W-1:0]);
      thresh_now = thresh;
      limit_now = limit;
   endtask

   task automatic send_chunk();
      int                  kind;
      int                  len;
      int                  amp;
      int                  mag;
      int                  v;
      int                  j;
      logic [SAMPLE_W-1:0] smp;
      kind = int'($urandom_range(9));
      if (kind == 0 && thresh_now <= 32768) begin
         // A single sample sitting on the threshold or one below it.
         mag = thresh_now - int'($urandom_range(1));
         if (mag < 0) mag = 0;
         smp = mag[SAMPLE_W-1:0];
         if ($urandom_range(1)) smp = -smp;
         send_beat(MODE_SAMPLE, smp, 1'b1);
      end else begin
         len = ($urandom_range(7) == 0) ? int'($urandom_range(24, 7))
                                        : int'($urandom_range(6, 1));
         if (kind <= 4) amp = -1;
         else if (kind <= 7) amp = thresh_now / 3;
         else amp = (thresh_now * 17 / 10 > 32767) ? 32767 : thresh_now * 17 / 10;
         for (j = 0; j < len; j++) begin
            if ($urandom_range(7) == 0) begin
               send_beat(MODE_TICK, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
            end
            if ($urandom_range(39) == 0) begin
               send_beat(MODE_START, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
            end
            if (amp < 0) begin
               smp = SAMPLE_W'($urandom());
            end else begin
               v = int'($urandom_range(2 * amp)) - amp;
               smp = v[SAMPLE_W-1:0];
            end
            send_beat(MODE_SAMPLE, smp, j == len - 1);
         end
      end
   endtask

   task automatic run_sessions(input int quota);
      int stop_at;
      int n_chunks;
      int span;
      int k;
      stop_at = beats_sent + quota;
      span = (limit_now < 8) ? limit_now + 2 : 4;
      while (beats_sent < stop_at) begin
         if ($urandom_range(19) == 0) begin
            send_beat(MODE_W'($urandom_range(3)), SAMPLE_W'($urandom()),
                      1'($urandom_range(1)));
         end else begin
            send_beat(MODE_START, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
            n_chunks = int'($urandom_range(8, 1));
            for (k = 0; k < n_chunks; k++) begin
               if ($urandom_range(49) == 0) settle();
               if ($urandom_range(3) == 0) begin
                  repeat ($urandom_range(span, 1)) begin
                     send_beat(MODE_TICK, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
                  end
               end
               send_chunk();
            end
            if ($urandom_range(1)) begin
               send_beat(MODE_STOP, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 33;
      recv_idle_pct = 88;

      // Register values from reset: threshold 200, silence limit 100.
      send_beat(MODE_SAMPLE, 16'h7FFF, 1'b1);
      send_beat(MODE_TICK, 16'h0000, 1'b0);
      send_beat(MODE_STOP, 16'h0000, 1'b0);
      send_beat(MODE_START, 16'h0000, 1'b0);
      send_beat(MODE_SAMPLE, 16'h8000, 1'b0);
      send_beat(MODE_START, 16'hFFFF, 1'b1);
      send_beat(MODE_SAMPLE, 16'h7FFF, 1'b1);
      send_beat(MODE_SAMPLE, 16'h0000, 1'b1);
      send_beat(MODE_TICK, 16'h0000, 1'b0);
      send_beat(MODE_TICK, 16'h0000, 1'b0);
      send_beat(MODE_SAMPLE, 16'd5, 1'b0);
      send_beat(MODE_SAMPLE, 16'hFFFF, 1'b0);
      send_beat(MODE_STOP, 16'h0000, 1'b0);
      send_beat(MODE_SAMPLE, 16'd100, 1'b1);
      send_beat(MODE_START, 16'h0000, 1'b0);
      send_beat(MODE_SAMPLE, 16'd1, 1'b1);
      send_beat(MODE_SAMPLE, 16'd200, 1'b1);
      send_beat(MODE_SAMPLE, 16'hFF39, 1'b1);
      send_beat(MODE_STOP, 16'h0000, 1'b0);
      settle();

      configure(1000, 0);
      send_beat(MODE_START, 16'h0000, 1'b0);
      send_beat(MODE_SAMPLE, 16'h8000, 1'b1);
      send_beat(MODE_SAMPLE, 16'd3, 1'b1);
      send_beat(MODE_SAMPLE, 16'h1234, 1'b1);
      settle();

      configure(int'($urandom_range(2000, 300)), int'($urandom_range(3, 1)));
      run_sessions(220);
      settle();
      configure(0, 2);
      run_sessions(130);
      settle();

      send_idle_pct = 88;
      recv_idle_pct = 33;
      configure(32768, 1);
      run_sessions(90);
      settle();
      configure(65535, 0);
      run_sessions(90);
      settle();
      configure(int'($urandom_range(5000, 50)), int'($urandom_range(6, 0)));
      run_sessions(220);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(32768, 1);
      send_beat(MODE_START, 16'h0000, 1'b0);
      repeat (CHUNK_MAX) send_beat(MODE_SAMPLE, 16'h8000, 1'b0);
      send_beat(MODE_SAMPLE, 16'd5, 1'b1);
      send_beat(MODE_STOP, 16'h0000, 1'b0);
      settle();

      configure(int'($urandom_range(3000, 100)), int'($urandom_range(5, 1)));
      run_sessions(170);
      settle();

      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/rvad_pkg.sv
src/rvad_ctrl.sv
src/rvad_dpath.sv
src/rms_voice_activity_detector.sv
verif/rvad_chunk_checker.sv
verif/rms_voice_activity_detector_tb.sv
